/* rtl/pbfx_pkg.sv */
// pbfx_pkg: shared types and constants for the protobuf profile field extractor
`timescale 1ns / 1ps

package pbfx_pkg;

    // parser modes, one-hot
    typedef enum logic [10:0] {
        M_OUT_KEY         = 11'h001,
        M_OUT_SKIP_VARINT = 11'h002,
        M_OUT_INFO_LEN    = 11'h004,
        M_OUT_SKIP_LEN    = 11'h008,
        M_OUT_SKIP_BYTES  = 11'h010,
        M_IN_KEY          = 11'h020,
        M_IN_SKIP_VARINT  = 11'h040,
        M_IN_SKIP_LEN     = 11'h080,
        M_IN_TEXT_LEN     = 11'h100,
        M_IN_SKIP_BYTES   = 11'h200,
        M_IN_TEXT         = 11'h400
    } mode_t;

    // result kinds
    localparam logic [2:0] KIND_NAME_BEGIN  = 3'd0;
    localparam logic [2:0] KIND_NAME_BYTE   = 3'd1;
    localparam logic [2:0] KIND_EMOJI_BEGIN = 3'd2;
    localparam logic [2:0] KIND_EMOJI_BYTE  = 3'd3;
    localparam logic [2:0] KIND_STATUS      = 3'd4;

    // protobuf wire types
    localparam logic [2:0] WT_VARINT = 3'd0;
    localparam logic [2:0] WT_FIXED64 = 3'd1;
    localparam logic [2:0] WT_LEN    = 3'd2;
    localparam logic [2:0] WT_FIXED32 = 3'd5;

    // field numbers and keys
    localparam logic [63:0] KEY_INFO   = 64'd10;
    localparam logic [31:0] FIELD_NAME  = 32'd2;
    localparam logic [31:0] FIELD_EMOJI = 32'd4;

    // register indexes (paddr bit 2)
    localparam logic REG_NAME_CAP  = 1'b0;
    localparam logic REG_EMOJI_CAP = 1'b1;

    localparam logic [8:0] NAME_CAP_RESET  = 9'd64;
    localparam logic [8:0] EMOJI_CAP_RESET = 9'd16;
    localparam logic [8:0] CAP_MAX         = 9'd256;

    // index of the last varint byte, at which only bit 0 may be set
    localparam logic [3:0] VARINT_LAST = 4'd9;

    // result queue
    localparam int RES_DEPTH = 4;
    localparam int RES_AW    = 2;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] text_byte;
        logic [7:0] text_length;
        logic       status;
        logic       name_seen;
        logic       emoji_seen;
        logic       run_last;
    } res_t;

endpackage

/* rtl/pbfx_in_if.sv */
// pbfx_in_if: input byte channel of the field extractor
`timescale 1ns / 1ps

interface pbfx_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       final_byte;

    modport source (output valid, output in_byte, output final_byte, input ready);
    modport sink (input valid, input in_byte, input final_byte, output ready);
endinterface

/* rtl/pbfx_out_if.sv */
// pbfx_out_if: result record channel of the field extractor
`timescale 1ns / 1ps

interface pbfx_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] text_byte;
    logic [7:0] text_length;
    logic       status;
    logic       name_seen;
    logic       emoji_seen;
    logic       run_last;

    modport source (output valid, output kind, output text_byte, output text_length,
                    output status, output name_seen, output emoji_seen, output run_last,
                    input ready);
    modport sink (input valid, input kind, input text_byte, input text_length,
                  input status, input name_seen, input emoji_seen, input run_last,
                  output ready);
endinterface

/* rtl/protobuf_profile_field_extractor.sv */
// protobuf_profile_field_extractor: streaming protobuf decoder for profile name and emoji
//
// Takes one byte of an encoded response per input beat and emits begin, text
// and status records. Each byte is decoded in the cycle it is accepted: the
// parser state registers take their next value at the input beat and the one
// or two records it causes go into a four-entry result queue. The block takes
// one byte per cycle as long as the queue holds two free entries, so a stream
// sustains one byte per cycle while the output side takes one record per
// cycle; a byte that gives a text record and ends the message gives two records.
// The user must set capacities through the APB port only while the block is idle;
// the block itself does not enforce this.
`timescale 1ns / 1ps

module protobuf_profile_field_extractor
    import pbfx_pkg::*;
#(
    parameter int LENGTH_BITS = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    pbfx_in_if.sink       in_ch,
    pbfx_out_if.source    out_ch,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    // configuration registers
    logic [8:0] name_cap_reg;
    logic [8:0] emoji_cap_reg;

    // parser state
    mode_t                  mode_reg, mode_next;
    logic [63:0]            acc_reg, acc_next;
    logic [3:0]             shift_reg, shift_next;
    logic [LENGTH_BITS-1:0] inner_rem_reg, inner_rem_next;
    logic [LENGTH_BITS-1:0] field_rem_reg, field_rem_next;
    logic                   sel_reg, sel_next;
    logic                   err_reg, err_next;
    logic                   info_reg, info_next;
    logic                   name_reg, name_next;
    logic                   emoji_reg, emoji_next;

    // result queue
    res_t                   res_mem [RES_DEPTH];
    logic [RES_AW-1:0]      wr_ptr_reg;
    logic [RES_AW-1:0]      rd_ptr_reg;
    logic [RES_AW:0]        count_reg;

    logic                   in_beat;
    logic                   out_beat;

    // varint step
    logic [7:0]             b;
    logic [6:0]             sh_prod;
    logic [63:0]            v_acc;
    logic [3:0]             v_shift;
    logic                   v_err;
    logic                   v_done;
    logic                   v_big;
    logic [LENGTH_BITS-1:0] ir1;
    logic                   inner;
    logic [31:0]            fnum;
    logic [2:0]             wtype;
    logic [8:0]             cap;

    // results of this beat
    res_t                   pres;
    logic                   pres_valid;
    res_t                   fres;
    res_t                   res_a;
    res_t                   res_b;
    logic [1:0]             push_n;
    logic                   bad;

    assign pready   = 1'b1;
    assign in_beat  = in_ch.valid && in_ch.ready;
    assign out_beat = out_ch.valid && out_ch.ready;
    assign b        = in_ch.in_byte;

    // apb register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            name_cap_reg  <= NAME_CAP_RESET;
            emoji_cap_reg <= EMOJI_CAP_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[2])
                REG_NAME_CAP:  name_cap_reg  <= pwdata[8:0];
                REG_EMOJI_CAP: emoji_cap_reg <= pwdata[8:0];
                default:       name_cap_reg  <= name_cap_reg;
            endcase
        end
    end

    // apb register read
    always_comb
    begin
        case (paddr[2])
            REG_NAME_CAP:  prdata = {23'd0, name_cap_reg};
            REG_EMOJI_CAP: prdata = {23'd0, emoji_cap_reg};
            default:       prdata = 32'd0;
        endcase
    end

    // varint accumulate for the current byte
    assign sh_prod = 7'(shift_reg) * 7'd7;
    assign v_acc   = ((shift_reg == 4'd0) ? 64'd0 : acc_reg)
                   | (64'(b[6:0]) << sh_prod[5:0]);
    assign v_shift = b[7] ? (shift_reg + 4'd1) : 4'd0;
    assign v_err   = ((shift_reg >= VARINT_LAST) && ((b & 8'hfe) != 8'd0))
                   || (b[7] && (shift_reg >= VARINT_LAST));
    assign v_done  = !v_err && !b[7];
    assign v_big   = (v_acc >> LENGTH_BITS) != 64'd0;
    assign fnum    = v_acc[34:3];
    assign wtype   = v_acc[2:0];

    assign inner = (mode_reg == M_IN_KEY) || (mode_reg == M_IN_SKIP_VARINT)
                || (mode_reg == M_IN_SKIP_LEN) || (mode_reg == M_IN_TEXT_LEN)
                || (mode_reg == M_IN_SKIP_BYTES) || (mode_reg == M_IN_TEXT);
    assign ir1 = (inner && (inner_rem_reg != '0)) ? (inner_rem_reg - LENGTH_BITS'(1))
                                                  : inner_rem_reg;
    assign cap = emoji_cap_reg;

    // decode one byte
    always_comb
    begin
        logic [8:0] cap_eff;
        mode_t      key_mode;

        mode_next      = mode_reg;
        acc_next       = acc_reg;
        shift_next     = shift_reg;
        inner_rem_next = inner_rem_reg;
        field_rem_next = field_rem_reg;
        sel_next       = sel_reg;
        err_next       = err_reg;
        info_next      = info_reg;
        name_next      = name_reg;
        emoji_next     = emoji_reg;
        pres           = '0;
        pres_valid     = 1'b0;
        fres           = '0;
        bad            = 1'b0;
        key_mode       = inner ? M_IN_KEY : M_OUT_KEY;
        cap_eff        = sel_reg ? cap : name_cap_reg;
        if (cap_eff > CAP_MAX)
        begin
            cap_eff = CAP_MAX;
        end

        if (!err_reg)
        begin
            inner_rem_next = ir1;
            case (mode_reg)
                M_OUT_KEY, M_IN_KEY:
                begin
                    acc_next   = v_acc;
                    shift_next = v_shift;
                    if (v_err)
                    begin
                        err_next = 1'b1;
                    end
                    else if (v_done)
                    begin
                        if (v_acc == 64'd0)
                        begin
                            err_next = 1'b1;
                        end
                        else if (!inner && (v_acc == KEY_INFO))
                        begin
                            mode_next = M_OUT_INFO_LEN;
                        end
                        else if (inner && ((fnum == FIELD_NAME) || (fnum == FIELD_EMOJI))
                                 && (wtype == WT_LEN))
                        begin
                            sel_next  = (fnum == FIELD_EMOJI);
                            mode_next = M_IN_TEXT_LEN;
                        end
                        else
                        begin
                            // skip an unknown field by wire type
                            case (wtype)
                                WT_VARINT:
                                    mode_next = inner ? M_IN_SKIP_VARINT : M_OUT_SKIP_VARINT;
                                WT_FIXED64:
                                begin
                                    field_rem_next = LENGTH_BITS'(8);
                                    mode_next = inner ? M_IN_SKIP_BYTES : M_OUT_SKIP_BYTES;
                                end
                                WT_LEN:
                                    mode_next = inner ? M_IN_SKIP_LEN : M_OUT_SKIP_LEN;
                                WT_FIXED32:
                                begin
                                    field_rem_next = LENGTH_BITS'(4);
                                    mode_next = inner ? M_IN_SKIP_BYTES : M_OUT_SKIP_BYTES;
                                end
                                default:
                                    err_next = 1'b1;
                            endcase
                        end
                    end
                end
                M_OUT_SKIP_VARINT, M_IN_SKIP_VARINT:
                begin
                    acc_next   = v_acc;
                    shift_next = v_shift;
                    if (v_err)
                    begin
                        err_next = 1'b1;
                    end
                    else if (v_done)
                    begin
                        mode_next = key_mode;
                    end
                end
                M_OUT_INFO_LEN:
                begin
                    acc_next   = v_acc;
                    shift_next = v_shift;
                    if (v_err || (v_done && v_big))
                    begin
                        err_next = 1'b1;
                    end
                    else if (v_done)
                    begin
                        info_next = 1'b1;
                        if (v_acc == 64'd0)
                        begin
                            mode_next = M_OUT_KEY;
                        end
                        else
                        begin
                            inner_rem_next = v_acc[LENGTH_BITS-1:0];
                            mode_next      = M_IN_KEY;
                        end
                    end
                end
                M_OUT_SKIP_LEN, M_IN_SKIP_LEN:
                begin
                    acc_next   = v_acc;
                    shift_next = v_shift;
                    if (v_err || (v_done && (v_big || (inner && (v_acc > 64'(ir1))))))
                    begin
                        err_next = 1'b1;
                    end
                    else if (v_done)
                    begin
                        if (v_acc == 64'd0)
                        begin
                            mode_next = key_mode;
                        end
                        else
                        begin
                            field_rem_next = v_acc[LENGTH_BITS-1:0];
                            mode_next = inner ? M_IN_SKIP_BYTES : M_OUT_SKIP_BYTES;
                        end
                    end
                end
                M_IN_TEXT_LEN:
                begin
                    acc_next   = v_acc;
                    shift_next = v_shift;
                    if (v_err || (v_done && (v_big || (v_acc > 64'(ir1))
                                             || (v_acc >= 64'(cap_eff)))))
                    begin
                        err_next = 1'b1;
                    end
                    else if (v_done)
                    begin
                        pres_valid       = 1'b1;
                        pres.kind        = sel_reg ? KIND_EMOJI_BEGIN : KIND_NAME_BEGIN;
                        pres.text_length = v_acc[7:0];
                        if (sel_reg)
                        begin
                            emoji_next = 1'b1;
                        end
                        else
                        begin
                            name_next = 1'b1;
                        end
                        if (v_acc == 64'd0)
                        begin
                            mode_next = M_IN_KEY;
                        end
                        else
                        begin
                            field_rem_next = v_acc[LENGTH_BITS-1:0];
                            mode_next      = M_IN_TEXT;
                        end
                    end
                end
                M_OUT_SKIP_BYTES, M_IN_SKIP_BYTES, M_IN_TEXT:
                begin
                    if (mode_reg == M_IN_TEXT)
                    begin
                        pres_valid     = 1'b1;
                        pres.kind      = sel_reg ? KIND_EMOJI_BYTE : KIND_NAME_BYTE;
                        pres.text_byte = b;
                    end
                    if (field_rem_reg > LENGTH_BITS'(1))
                    begin
                        field_rem_next = field_rem_reg - LENGTH_BITS'(1);
                    end
                    else
                    begin
                        field_rem_next = '0;
                        mode_next      = key_mode;
                    end
                end
                default:
                    err_next = 1'b1;
            endcase

            // nested message must end on a field boundary
            if (inner && !err_next && (ir1 == '0))
            begin
                if ((mode_next == M_IN_KEY) && (shift_next == 4'd0))
                begin
                    mode_next = M_OUT_KEY;
                end
                else
                begin
                    err_next = 1'b1;
                end
            end
        end

        // final status and clear
        if (in_ch.final_byte)
        begin
            bad = err_next || !info_next || (mode_next != M_OUT_KEY) || (shift_next != 4'd0);
            fres.kind       = KIND_STATUS;
            fres.status     = bad;
            fres.name_seen  = !bad && name_next;
            fres.emoji_seen = !bad && emoji_next;
            fres.run_last   = 1'b1;
            mode_next       = M_OUT_KEY;
            acc_next        = 64'd0;
            shift_next      = 4'd0;
            inner_rem_next  = '0;
            field_rem_next  = '0;
            sel_next        = 1'b0;
            err_next        = 1'b0;
            info_next       = 1'b0;
            name_next       = 1'b0;
            emoji_next      = 1'b0;
        end
    end

    // order the records of this beat
    always_comb
    begin
        res_a  = pres;
        res_b  = fres;
        push_n = 2'd0;
        if (pres_valid && in_ch.final_byte)
        begin
            push_n = 2'd2;
        end
        else if (pres_valid)
        begin
            res_a.run_last = 1'b1;
            push_n = 2'd1;
        end
        else if (in_ch.final_byte)
        begin
            res_a  = fres;
            push_n = 2'd1;
        end
    end

    // parser state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= M_OUT_KEY;
            acc_reg       <= 64'd0;
            shift_reg     <= 4'd0;
            inner_rem_reg <= '0;
            field_rem_reg <= '0;
            sel_reg       <= 1'b0;
            err_reg       <= 1'b0;
            info_reg      <= 1'b0;
            name_reg      <= 1'b0;
            emoji_reg     <= 1'b0;
        end
        else if (in_beat)
        begin
            mode_reg      <= mode_next;
            acc_reg       <= acc_next;
            shift_reg     <= shift_next;
            inner_rem_reg <= inner_rem_next;
            field_rem_reg <= field_rem_next;
            sel_reg       <= sel_next;
            err_reg       <= err_next;
            info_reg      <= info_next;
            name_reg      <= name_next;
            emoji_reg     <= emoji_next;
        end
    end

    // result queue storage
    always_ff @(posedge clk)
    begin
        if (in_beat && (push_n != 2'd0))
        begin
            res_mem[wr_ptr_reg] <= res_a;
            if (push_n == 2'd2)
            begin
                res_mem[wr_ptr_reg + RES_AW'(1)] <= res_b;
            end
        end
    end

    // result queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (in_beat)
            begin
                wr_ptr_reg <= wr_ptr_reg + RES_AW'(push_n);
            end
            if (out_beat)
            begin
                rd_ptr_reg <= rd_ptr_reg + RES_AW'(1);
            end
            count_reg <= count_reg + (in_beat ? (RES_AW+1)'(push_n) : '0)
                       - (out_beat ? (RES_AW+1)'(1) : '0);
        end
    end

    // handshakes and output payload
    assign in_ch.ready       = count_reg <= (RES_AW+1)'(RES_DEPTH - 2);
    assign out_ch.valid      = count_reg != '0;
    assign out_ch.kind        = res_mem[rd_ptr_reg].kind;
    assign out_ch.text_byte   = res_mem[rd_ptr_reg].text_byte;
    assign out_ch.text_length = res_mem[rd_ptr_reg].text_length;
    assign out_ch.status      = res_mem[rd_ptr_reg].status;
    assign out_ch.name_seen   = res_mem[rd_ptr_reg].name_seen;
    assign out_ch.emoji_seen  = res_mem[rd_ptr_reg].emoji_seen;
    assign out_ch.run_last    = res_mem[rd_ptr_reg].run_last;

endmodule

/* tb/protobuf_profile_field_extractor_test.sv */
// protobuf_profile_field_extractor_test: byte-stream checks of the profile field extractor
`timescale 1ns / 1ps

module protobuf_profile_field_extractor_test
    import pbfx_pkg::*;
();

    localparam int          LENGTH_BITS = 32;
    localparam logic [63:0] LEN_MAX     = {64{1'b1}} >> (64 - LENGTH_BITS);
    localparam int          STALL_LIMIT = 2000;
    localparam int          PHASES      = 10;
    localparam int          PHASE_BYTES = 120;

    typedef logic [7:0] byte_q_t[$];

    // expected record tracker: mirrors the decoder and holds records not yet seen
    class field_record_tracker;
        res_t        due_records[$];
        res_t        step_recs[$];
        int unsigned mismatches;
        logic [8:0]  name_cap;
        logic [8:0]  emoji_cap;
        mode_t       mode;
        logic [63:0] acc;
        logic [3:0]  shift;
        logic [63:0] inner_left;
        logic [63:0] field_left;
        logic        emoji_sel;
        logic        err;
        logic        info_seen;
        logic        name_flag;
        logic        emoji_flag;

        function new();
            name_cap   = NAME_CAP_RESET;
            emoji_cap  = EMOJI_CAP_RESET;
            mismatches = 0;
            clear_parse();
        endfunction

        function void set_cap(logic idx, logic [8:0] value);
            if (idx == REG_NAME_CAP)
                name_cap = value;
            else
                emoji_cap = value;
        endfunction

        function int pending();
            return due_records.size();
        endfunction

        function void clear_parse();
            mode       = M_OUT_KEY;
            acc        = '0;
            shift      = '0;
            inner_left = '0;
            field_left = '0;
            emoji_sel  = 1'b0;
            err        = 1'b0;
            info_seen  = 1'b0;
            name_flag  = 1'b0;
            emoji_flag = 1'b0;
        endfunction

        function void add_rec(logic [2:0] kind, logic [7:0] tbyte, logic [7:0] tlen);
            res_t r;
            r             = '0;
            r.kind        = kind;
            r.text_byte   = tbyte;
            r.text_length = tlen;
            step_recs.push_back(r);
        endfunction

        // one varint byte: 0 needs more, 1 done, 2 overlong
        function int varint_take(logic [7:0] b);
            if (shift >= VARINT_LAST && (b & 8'hfe) != 8'h00)
                return 2;
            if (shift == 4'd0)
                acc = '0;
            acc = acc | ({57'd0, b[6:0]} << ((int'(shift) * 7) & 63));
            if (!b[7])
            begin
                shift = '0;
                return 1;
            end
            shift = shift + 4'd1;
            if (shift > VARINT_LAST)
                return 2;
            return 0;
        endfunction

        // enter the skip mode for an unknown field
        function void enter_skip(logic [2:0] wtype, logic inner);
            case (wtype)
                WT_VARINT:
                    mode = inner ? M_IN_SKIP_VARINT : M_OUT_SKIP_VARINT;
                WT_FIXED64:
                begin
                    field_left = 64'd8;
                    mode       = inner ? M_IN_SKIP_BYTES : M_OUT_SKIP_BYTES;
                end
                WT_LEN:
                    mode = inner ? M_IN_SKIP_LEN : M_OUT_SKIP_LEN;
                WT_FIXED32:
                begin
                    field_left = 64'd4;
                    mode       = inner ? M_IN_SKIP_BYTES : M_OUT_SKIP_BYTES;
                end
                default:
                    err = 1'b1;
            endcase
        endfunction

        function void decode_byte(logic [7:0] b);
            logic        inner;
            mode_t       key_mode;
            int          r;
            logic [63:0] v;
            logic [8:0]  cap;
            logic [31:0] fnum;
            inner    = (mode >= M_IN_KEY);
            key_mode = inner ? M_IN_KEY : M_OUT_KEY;
            if (inner && inner_left != 0)
                inner_left = inner_left - 1;
            case (mode)
                M_OUT_KEY, M_IN_KEY:
                begin
                    r = varint_take(b);
                    if (r == 2)
                        err = 1'b1;
                    else if (r == 1)
                    begin
                        v = acc;
                        if (v == 0)
                            err = 1'b1;
                        else if (!inner)
                        begin
                            if (v == KEY_INFO)
                                mode = M_OUT_INFO_LEN;
                            else
                                enter_skip(v[2:0], 1'b0);
                        end
                        else
                        begin
                            // inner field number only on its low 32 bits
                            fnum = v[34:3];
                            if ((fnum == FIELD_NAME || fnum == FIELD_EMOJI) && v[2:0] == WT_LEN)
                            begin
                                emoji_sel = (fnum == FIELD_EMOJI);
                                mode      = M_IN_TEXT_LEN;
                            end
                            else
                                enter_skip(v[2:0], 1'b1);
                        end
                    end
                end
                M_OUT_SKIP_VARINT, M_IN_SKIP_VARINT:
                begin
                    r = varint_take(b);
                    if (r == 2)
                        err = 1'b1;
                    else if (r == 1)
                        mode = key_mode;
                end
                M_OUT_INFO_LEN:
                begin
                    r = varint_take(b);
                    if (r == 2)
                        err = 1'b1;
                    else if (r == 1)
                    begin
                        v = acc;
                        if (v > LEN_MAX)
                            err = 1'b1;
                        else
                        begin
                            info_seen = 1'b1;
                            if (v == 0)
                                mode = M_OUT_KEY;
                            else
                            begin
                                inner_left = v;
                                mode       = M_IN_KEY;
                            end
                        end
                    end
                end
                M_OUT_SKIP_LEN, M_IN_SKIP_LEN:
                begin
                    r = varint_take(b);
                    if (r == 2)
                        err = 1'b1;
                    else if (r == 1)
                    begin
                        v = acc;
                        if (v > LEN_MAX || (inner && v > inner_left))
                            err = 1'b1;
                        else if (v == 0)
                            mode = key_mode;
                        else
                        begin
                            field_left = v;
                            mode       = inner ? M_IN_SKIP_BYTES : M_OUT_SKIP_BYTES;
                        end
                    end
                end
                M_IN_TEXT_LEN:
                begin
                    r = varint_take(b);
                    if (r == 2)
                        err = 1'b1;
                    else if (r == 1)
                    begin
                        v   = acc;
                        cap = emoji_sel ? emoji_cap : name_cap;
                        if (cap > CAP_MAX)
                            cap = CAP_MAX;
                        if (v > LEN_MAX || v > inner_left || v >= {55'd0, cap})
                            err = 1'b1;
                        else
                        begin
                            // begin record goes out as soon as the length checks pass
                            add_rec(emoji_sel ? KIND_EMOJI_BEGIN : KIND_NAME_BEGIN, 8'd0, v[7:0]);
                            if (emoji_sel)
                                emoji_flag = 1'b1;
                            else
                                name_flag = 1'b1;
                            if (v == 0)
                                mode = M_IN_KEY;
                            else
                            begin
                                field_left = v;
                                mode       = M_IN_TEXT;
                            end
                        end
                    end
                end
                M_OUT_SKIP_BYTES, M_IN_SKIP_BYTES, M_IN_TEXT:
                begin
                    if (mode == M_IN_TEXT)
                        add_rec(emoji_sel ? KIND_EMOJI_BYTE : KIND_NAME_BYTE, b, 8'd0);
                    if (field_left != 0)
                        field_left = field_left - 1;
                    if (field_left == 0)
                        mode = key_mode;
                end
                default:
                    err = 1'b1;
            endcase
            // nested message must close exactly on a key boundary
            if (inner && !err && inner_left == 0)
            begin
                if (mode == M_IN_KEY && shift == 0)
                    mode = M_OUT_KEY;
                else
                    err = 1'b1;
            end
        endfunction

        // note one accepted input beat and queue the records it causes
        function void take_byte(logic [7:0] b, logic fin);
            logic bad;
            res_t r;
            step_recs.delete();
            if (!err)
                decode_byte(b);
            if (fin)
            begin
                bad          = err || !info_seen || mode != M_OUT_KEY || shift != 0;
                r            = '0;
                r.kind       = KIND_STATUS;
                r.status     = bad;
                r.name_seen  = !bad && name_flag;
                r.emoji_seen = !bad && emoji_flag;
                step_recs.push_back(r);
                clear_parse();
            end
            if (step_recs.size() > 0)
            begin
                r          = step_recs.pop_back();
                r.run_last = 1'b1;
                step_recs.push_back(r);
            end
            foreach (step_recs[i])
                due_records.push_back(step_recs[i]);
        endfunction

        function void field_check(string fname, logic [7:0] want, logic [7:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, got %0d", fname, want, got);
                mismatches++;
            end
        endfunction

        // compare one output beat against the oldest expected record
        function void check_record(res_t got);
            res_t want;
            if (due_records.size() == 0)
            begin
                $error("record with none expected: kind %0d", got.kind);
                mismatches++;
                return;
            end
            want = due_records.pop_front();
            field_check("kind", 8'(want.kind), 8'(got.kind));
            field_check("text_byte", want.text_byte, got.text_byte);
            field_check("text_length", want.text_length, got.text_length);
            field_check("status", 8'(want.status), 8'(got.status));
            field_check("name_seen", 8'(want.name_seen), 8'(got.name_seen));
            field_check("emoji_seen", 8'(want.emoji_seen), 8'(got.emoji_seen));
            field_check("run_last", 8'(want.run_last), 8'(got.run_last));
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    bit          burst;
    int          idle_cycles = 0;

    field_record_tracker records = new();

    pbfx_in_if  in_ch();
    pbfx_out_if out_ch();

    protobuf_profile_field_extractor #(
        .LENGTH_BITS(LENGTH_BITS)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch),
        .out_ch(out_ch),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // encoding helpers: varints sometimes padded up to ten bytes
    function automatic void put_varint(ref byte_q_t q, input logic [63:0] v);
        int groups;
        int total;
        groups = 1;
        while (groups < 10 && (v >> (7 * groups)) != 0)
            groups++;
        total = groups;
        if ($urandom_range(0, 7) == 0)
            total = $urandom_range(groups, 10);
        for (int i = 0; i < total; i++)
            q.push_back({(i < total - 1) ? 1'b1 : 1'b0, 7'(v >> (7 * i))});
    endfunction

    function automatic void put_random(ref byte_q_t q, input int n);
        repeat (n)
            q.push_back(8'($urandom_range(0, 255)));
    endfunction

    function automatic logic [63:0] wide_value();
        return {$urandom, $urandom} >> $urandom_range(0, 63);
    endfunction

    // unknown field of a legal wire type
    function automatic void put_unknown(ref byte_q_t q);
        logic [63:0] fnum;
        logic [2:0]  wtype;
        int          n;
        fnum = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(5, 100000))
                                           : 64'($urandom_range(5, 15));
        case ($urandom_range(0, 3))
            0: wtype = WT_VARINT;
            1: wtype = WT_FIXED64;
            2: wtype = WT_LEN;
            default: wtype = WT_FIXED32;
        endcase
        put_varint(q, (fnum << 3) | {61'd0, wtype});
        case (wtype)
            WT_VARINT: put_varint(q, wide_value());
            WT_FIXED64: put_random(q, 8);
            WT_FIXED32: put_random(q, 4);
            default:
            begin
                n = $urandom_range(0, 6);
                put_varint(q, 64'(n));
                put_random(q, n);
            end
        endcase
    endfunction

    // text length mostly legal, sometimes at the capacity edges
    function automatic int text_length_for(logic [8:0] cap);
        int eff;
        int r;
        eff = (cap > CAP_MAX) ? 256 : int'(cap);
        r   = $urandom_range(0, 59);
        if (eff == 0)
            return $urandom_range(0, 2);
        if (r == 0)
            return eff - 1;
        if (r == 1)
            return eff;
        return $urandom_range(0, (eff - 1 < 12) ? eff - 1 : 12);
    endfunction

    function automatic void put_text(ref byte_q_t q, input bit emoji);
        logic [63:0] fnum;
        int          n;
        fnum = emoji ? 64'(FIELD_EMOJI) : 64'(FIELD_NAME);
        // high field bits that only the low-32 compare ignores
        if ($urandom_range(0, 7) == 0)
            fnum = fnum | (64'($urandom_range(1, 7)) << 32);
        put_varint(q, (fnum << 3) | 64'(WT_LEN));
        n = text_length_for(emoji ? records.emoji_cap : records.name_cap);
        put_varint(q, 64'(n));
        put_random(q, n);
    endfunction

    // well-formed response with random content
    function automatic void build_profile(ref byte_q_t q);
        byte_q_t body;
        repeat ($urandom_range(0, 2))
            put_unknown(q);
        if ($urandom_range(0, 11) != 0)
        begin
            repeat ($urandom_range(0, 4))
            begin
                case ($urandom_range(0, 2))
                    0: put_text(body, 1'b0);
                    1: put_text(body, 1'b1);
                    default: put_unknown(body);
                endcase
            end
            put_varint(q, KEY_INFO);
            put_varint(q, 64'(body.size()));
            q = {q, body};
        end
        repeat ($urandom_range(0, 1))
            put_unknown(q);
        if (q.size() == 0)
        begin
            put_varint(q, KEY_INFO);
            put_varint(q, 64'd0);
        end
    endfunction

    // broken or unusual responses
    function automatic void build_special(ref byte_q_t q);
        byte_q_t     body;
        int          idx;
        int          stated;
        logic [63:0] fnum;
        case ($urandom_range(0, 7))
            0:
            begin
                // zero key, outer or nested
                if ($urandom_range(0, 1) == 0)
                begin
                    build_profile(q);
                    q.push_back(8'h00);
                    put_random(q, $urandom_range(0, 2));
                end
                else
                begin
                    put_varint(q, KEY_INFO);
                    put_varint(q, 64'd1);
                    q.push_back(8'h00);
                end
            end
            1:
            begin
                // reserved wire types
                idx  = $urandom_range(0, 3);
                fnum = 64'($urandom_range(1, 40));
                if ($urandom_range(0, 1) == 0)
                begin
                    put_varint(q, (fnum << 3) | 64'((idx < 2) ? 3 + idx : 4 + idx));
                    put_random(q, $urandom_range(0, 2));
                end
                else
                begin
                    put_varint(body, (fnum << 3) | 64'((idx < 2) ? 3 + idx : 4 + idx));
                    put_random(body, $urandom_range(0, 2));
                    put_varint(q, KEY_INFO);
                    put_varint(q, 64'(body.size()));
                    q = {q, body};
                end
            end
            2:
            begin
                // ten-byte varint value, last byte legal or not
                put_varint(q, 64'(WT_VARINT) | 64'h8);
                repeat (9)
                    q.push_back(8'h80 | 8'($urandom_range(0, 127)));
                case ($urandom_range(0, 2))
                    0: q.push_back(8'h00);
                    1: q.push_back(8'h01);
                    default: q.push_back(8'($urandom_range(0, 255)));
                endcase
                put_varint(q, KEY_INFO);
                put_varint(q, 64'd0);
            end
            3:
            begin
                // lengths around the length limit
                put_varint(q, ($urandom_range(0, 1) == 0) ? KEY_INFO : 64'h1a);
                case ($urandom_range(0, 2))
                    0: put_varint(q, LEN_MAX);
                    1: put_varint(q, LEN_MAX + 64'd1);
                    default: put_varint(q, wide_value());
                endcase
                put_random(q, $urandom_range(0, 2));
            end
            4:
            begin
                // nested length that may disagree with its content
                put_text(body, 1'($urandom_range(0, 1)));
                if ($urandom_range(0, 1) == 0)
                    put_unknown(body);
                stated = body.size() + $urandom_range(0, 4) - 2;
                if (stated < 0)
                    stated = 0;
                put_varint(q, KEY_INFO);
                put_varint(q, 64'(stated));
                q = {q, body};
            end
            5:
            begin
                // outer field 1 plus high bits is just another field
                put_varint(q, (((64'd1 << 32) | 64'd1) << 3) | 64'(WT_LEN));
                idx = $urandom_range(0, 3);
                put_varint(q, 64'(idx));
                put_random(q, idx);
                build_profile(q);
            end
            6:
                put_random(q, $urandom_range(1, 10));
            default:
            begin
                // valid response cut short, with one byte changed or with one byte inserted
                build_profile(q);
                idx = $urandom_range(0, q.size() - 1);
                case ($urandom_range(0, 2))
                    0: if (q.size() > 1) q = q[0:$urandom_range(0, q.size() - 2)];
                    1: q[idx] = 8'($urandom_range(0, 255));
                    default: q.insert(idx, 8'($urandom_range(0, 255)));
                endcase
            end
        endcase
    endfunction

    // one input beat after a random gap
    task automatic send_byte(logic [7:0] b, logic fin);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.in_byte    <= b;
        in_ch.final_byte <= fin;
        @(posedge clk);
        while (in_ch.ready !== 1'b1)
            @(posedge clk);
        records.take_byte(b, fin);
    endtask

    task automatic send_message(byte_q_t msg);
        burst = ($urandom_range(0, 4) == 0);
        foreach (msg[i])
            send_byte(msg[i], (i == msg.size() - 1));
    endtask

    // wait for every expected record, then let the pipeline settle
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (records.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic reg_write(logic idx, logic [8:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {23'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (pready !== 1'b1)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        records.set_cap(idx, value);
    endtask

    // output side: random back-pressure, check every beat
    initial
    begin
        res_t got;
        int   gap;
        out_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            gap = burst ? 0 : $urandom_range(0, 4);
            if (gap > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
            while (out_ch.valid !== 1'b1)
                @(posedge clk);
            got = {out_ch.kind, out_ch.text_byte, out_ch.text_length, out_ch.status,
                   out_ch.name_seen, out_ch.emoji_seen, out_ch.run_last};
            records.check_record(got);
        end
    end

    // watchdog on cycles with no beat on any port
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (psel && penable && pwrite && pready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("protobuf_profile_field_extractor_test: FAIL");
                $finish;
            end
        end
    end

    // stimulus
    initial
    begin
        byte_q_t    msg;
        int         phase_bytes;
        logic [8:0] ncap;
        logic [8:0] ecap;
        burst            = 1'b0;
        rst_n            = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.in_byte    = 8'd0;
        in_ch.final_byte = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: name and emoji with two records on the last byte
        msg = '{8'h0a, 8'h06, 8'h12, 8'h01, 8'h41, 8'h22, 8'h01, 8'hf0};
        send_message(msg);
        // zero key
        msg = '{8'h00};
        send_message(msg);
        // reserved wire types
        msg = '{8'h0b};
        send_message(msg);
        msg = '{8'h0f};
        send_message(msg);
        // message ends inside a varint
        msg = '{8'h0a, 8'h00, 8'hff};
        send_message(msg);
        // text overruns its nested message, trailing byte ignored
        msg = '{8'h0a, 8'h02, 8'h12, 8'h05, 8'h00};
        send_message(msg);
        drain();

        // random phases, capacity extremes first
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    ncap = 9'd1;
                    ecap = 9'd1;
                end
                1:
                begin
                    ncap = 9'd256;
                    ecap = 9'd256;
                end
                2:
                begin
                    ncap = 9'd0;
                    ecap = 9'd511;
                end
                3:
                begin
                    ncap = 9'd511;
                    ecap = 9'd0;
                end
                default:
                begin
                    ncap = 9'($urandom_range(1, 256));
                    ecap = 9'($urandom_range(1, 256));
                end
            endcase
            reg_write(REG_NAME_CAP, ncap);
            reg_write(REG_EMOJI_CAP, ecap);
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES)
            begin
                msg.delete();
                if ($urandom_range(0, 9) < 7)
                    build_profile(msg);
                else
                    build_special(msg);
                send_message(msg);
                phase_bytes += msg.size();
            end
            drain();
        end

        if (records.mismatches == 0 && records.pending() == 0)
            $display("protobuf_profile_field_extractor_test: PASS");
        else
            $display("protobuf_profile_field_extractor_test: FAIL");
        $finish;
    end

endmodule
